// ===== design/distinct_word_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Distinct word counter assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_WORD_COUNTER_TOP_ASSERT_SVH
`define DISTINCT_WORD_COUNTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWC_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distinct word counter package
// Shared constants, payload types and the token flags of the cell chain.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DEF_MAX_WORDS = 32;
    localparam int DEF_MAX_LEN   = 16;

    localparam logic [7:0]  SEPARATOR = 8'd32;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] word_count;
        logic [5:0]  distinct_count;
        logic        word_truncated;
        logic        table_full;
    } out_item_t;

    // Status that travels with a word along the chain.
    typedef struct packed {
        logic valid;
        logic done;
        logic inserted;
    } tok_flags_t;

endpackage

// ===== design/dwc_cell.sv =====
// ----------------------------------------------------------------------------
// Distinct word counter table cell
// Holds one stored word, compares or captures the passing word token and
// hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module dwc_cell #(
    parameter int MAX_LEN = dwc_pkg::DEF_MAX_LEN,
    parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  dwc_pkg::tok_flags_t       tok_in_flags,
    input  logic [LEN_W-1:0]          tok_in_len,
    input  logic [MAX_LEN-1:0][7:0]   tok_in_chars,
    output dwc_pkg::tok_flags_t       tok_out_flags,
    output logic [LEN_W-1:0]          tok_out_len,
    output logic [MAX_LEN-1:0][7:0]   tok_out_chars,
    output logic                      occupied
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [LEN_W-1:0]        len_reg;
    logic [MAX_LEN-1:0][7:0] chars_reg;
    dwc_pkg::tok_flags_t     flags_reg;
    dwc_pkg::tok_flags_t     flags_next;
    logic [LEN_W-1:0]        tlen_reg;
    logic [MAX_LEN-1:0][7:0] tchars_reg;
    logic [MAX_LEN-1:0]      byte_ok;
    logic                    match;
    logic                    capture;

    // Only the bytes below the word length take part in the compare.
    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            byte_ok[k] = (LEN_W'(k) >= tok_in_len) || (chars_reg[k] == tok_in_chars[k]);
        end
    end

    assign match   = valid_reg && (len_reg == tok_in_len) && (&byte_ok);
    assign capture = tok_in_flags.valid && !tok_in_flags.done && !valid_reg;

    always_comb
    begin
        flags_next = tok_in_flags;
        valid_next = valid_reg;
        if (tok_in_flags.valid && !tok_in_flags.done)
        begin
            if (match)
            begin
                flags_next.done = 1'b1;
            end
            else if (capture)
            begin
                flags_next.done     = 1'b1;
                flags_next.inserted = 1'b1;
                valid_next          = 1'b1;
            end
        end
        if (clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tlen_reg   <= tok_in_len;
        tchars_reg <= tok_in_chars;
        if (capture)
        begin
            len_reg   <= tok_in_len;
            chars_reg <= tok_in_chars;
        end
    end

    assign tok_out_flags = flags_reg;
    assign tok_out_len   = tlen_reg;
    assign tok_out_chars = tchars_reg;
    assign occupied      = valid_reg;

endmodule

// ===== design/distinct_word_counter_top.sv =====
// ----------------------------------------------------------------------------
// Distinct word counter
// Counts the words of a sentence and how many of them are distinct.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a sentence come in on the char channel, one per request, with
// char_data.last set on the final byte. Byte 32 separates words; runs of
// spaces give no empty words. One result request leaves on the result
// channel per sentence, after its final byte.
// A word byte leaves the block ready for the next byte. A byte that ends
// a word (a space or the final byte) starts a walk of the word through the
// row of MAX_WORDS table cells, one cell per cycle, and char_stall holds
// the next byte until the walk is done. The result is written in the emit
// state, after the walk of the last word of the sentence, if there is
// one.
// The result sits in an output register; a stalled receiver holds it, and
// the block keeps taking bytes until the next result must be written.
// After a result the table and all counts are clear for the next sentence.
// Reset clears the table valid bits and all counts at once.
// ----------------------------------------------------------------------------
`include "distinct_word_counter_top_assert.svh"

module distinct_word_counter_top #(
    parameter int MAX_WORDS = dwc_pkg::DEF_MAX_WORDS,
    parameter int MAX_LEN   = dwc_pkg::DEF_MAX_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  dwc_pkg::in_item_t  char_data,
    output logic               result_valid,
    input  logic               result_stall,
    output dwc_pkg::out_item_t result_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WALK,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAX_LEN-1:0][7:0] cur_word_reg, cur_word_next;
    logic [LEN_W-1:0]        cur_len_reg, cur_len_next;
    logic [15:0]             total_reg, total_next;
    logic [CNT_W-1:0]        stored_reg, stored_next;
    logic                    trunc_reg, trunc_next;
    logic                    ovf_reg, ovf_next;
    logic                    last_pend_reg, last_pend_next;
    logic                    result_valid_reg, result_valid_next;
    dwc_pkg::out_item_t      result_reg, result_next;

    logic                    accept;
    logic                    launch;
    logic                    clear;
    logic                    emit;
    logic [CNT_W+5:0]        stored_ext;

    dwc_pkg::tok_flags_t     chain_flags [MAX_WORDS+1];
    logic [LEN_W-1:0]        chain_len   [MAX_WORDS+1];
    logic [MAX_LEN-1:0][7:0] chain_chars [MAX_WORDS+1];
    logic [MAX_WORDS-1:0]    occupied;

    assign accept     = char_valid && !char_stall;
    assign char_stall = (state_reg != S_IDLE);
    assign stored_ext = (CNT_W + 6)'(stored_reg);

    // A new word enters the first cell with no match seen yet.
    always_comb
    begin
        chain_flags[0]          = '0;
        chain_flags[0].valid    = launch;
        chain_len[0]            = cur_len_reg;
        chain_chars[0]          = cur_word_reg;
    end

    for (genvar i = 0; i < MAX_WORDS; i++)
    begin : g_cell
        dwc_cell #(
            .MAX_LEN (MAX_LEN),
            .LEN_W   (LEN_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .clear         (clear),
            .tok_in_flags  (chain_flags[i]),
            .tok_in_len    (chain_len[i]),
            .tok_in_chars  (chain_chars[i]),
            .tok_out_flags (chain_flags[i+1]),
            .tok_out_len   (chain_len[i+1]),
            .tok_out_chars (chain_chars[i+1]),
            .occupied      (occupied[i])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_word_next     = cur_word_reg;
        cur_len_next      = cur_len_reg;
        total_next        = total_reg;
        stored_next       = stored_reg;
        trunc_next        = trunc_reg;
        ovf_next          = ovf_reg;
        last_pend_next    = last_pend_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        launch            = 1'b0;
        clear             = 1'b0;
        emit              = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (char_data.char_code != dwc_pkg::SEPARATOR)
                    begin
                        if (cur_len_reg < LEN_W'(MAX_LEN))
                        begin
                            cur_word_next[cur_len_reg[IDX_W-1:0]] = char_data.char_code;
                            cur_len_next = cur_len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            trunc_next = 1'b1;
                        end
                    end
                    if ((char_data.char_code == dwc_pkg::SEPARATOR) || char_data.last)
                    begin
                        last_pend_next = char_data.last;
                        state_next     = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH:
            begin
                if (cur_len_reg != '0)
                begin
                    launch       = 1'b1;
                    cur_len_next = '0;
                    if (total_reg != dwc_pkg::COUNT_MAX)
                    begin
                        total_next = total_reg + 16'd1;
                    end
                    state_next = S_WALK;
                end
                else if (last_pend_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (chain_flags[MAX_WORDS].valid)
                begin
                    if (chain_flags[MAX_WORDS].inserted)
                    begin
                        stored_next = stored_reg + CNT_W'(1);
                    end
                    // A word that neither matched nor found a free cell is dropped.
                    if (!chain_flags[MAX_WORDS].done)
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = last_pend_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    emit                       = 1'b1;
                    clear                      = 1'b1;
                    result_valid_next          = 1'b1;
                    result_next.word_count     = total_reg;
                    result_next.distinct_count = stored_ext[5:0];
                    result_next.word_truncated = trunc_reg;
                    result_next.table_full     = ovf_reg;
                    total_next                 = '0;
                    stored_next                = '0;
                    trunc_next                 = 1'b0;
                    ovf_next                   = 1'b0;
                    cur_len_next               = '0;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (result_valid_reg && !result_stall && !emit)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_len_reg      <= '0;
            total_reg        <= '0;
            stored_reg       <= '0;
            trunc_reg        <= 1'b0;
            ovf_reg          <= 1'b0;
            last_pend_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_len_reg      <= cur_len_next;
            total_reg        <= total_next;
            stored_reg       <= stored_next;
            trunc_reg        <= trunc_next;
            ovf_reg          <= ovf_next;
            last_pend_reg    <= last_pend_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_word_reg <= cur_word_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `DWC_CHECK(chain_prefix_a, 1'b1, (occupied & (occupied + MAX_WORDS'(1))) == '0, "table cells not filled in order")
    `DWC_CHECK(stored_limit_a, 1'b1, stored_reg <= CNT_W'(MAX_WORDS), "stored word count beyond table size")
    `DWC_CHECK(exit_in_walk_a, chain_flags[MAX_WORDS].valid, state_reg == S_WALK, "word left the chain outside a walk")
    `DWC_CHECK_NEXT(clear_after_emit_a, emit, (total_reg == '0) && (stored_reg == '0) && (occupied == '0), "state not cleared after a result")

endmodule

// ===== tb/distinct_word_checker.sv =====
// ----------------------------------------------------------------------------
// Distinct word counter checker
// Watches the char and result channels and keeps its own copy of the word
// table. For every sentence it works out the counts and flags due at the
// final byte, then compares each result request with the oldest of them.
// ----------------------------------------------------------------------------
module distinct_word_checker
    import dwc_pkg::*;
#(
    parameter int MAX_WORDS = DEF_MAX_WORDS,
    parameter int MAX_LEN   = DEF_MAX_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_stall,
    input  in_item_t  char_data,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result_data,
    output int        mismatches,
    output int        results_checked,
    output int        results_waiting
);

    localparam int PRINT_LIMIT = 40;

    logic [7:0]  table_chars [MAX_WORDS][MAX_LEN];
    int unsigned table_len [MAX_WORDS];
    int unsigned table_used;
    logic [7:0]  word_buf [MAX_LEN];
    int unsigned word_len;
    int unsigned word_total;
    bit          saw_long;
    bit          saw_drop;
    out_item_t   expected_totals [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("ERROR result %0d: %s is %0d, expected %0d",
                     results_checked, what, got, want);
        end
    endtask

    // A finished word is looked up by its stored bytes; a new one takes the
    // next free entry, or sets the full flag when none is left.
    function automatic void close_word();
        bit found;
        found = 1'b0;
        if (word_len == 0)
            return;
        if (word_total < COUNT_MAX)
            word_total++;
        for (int e = 0; e < table_used && !found; e++)
        begin
            if (table_len[e] == word_len)
            begin
                found = 1'b1;
                for (int k = 0; k < word_len; k++)
                begin
                    if (table_chars[e][k] != word_buf[k])
                        found = 1'b0;
                end
            end
        end
        if (!found)
        begin
            if (table_used < MAX_WORDS)
            begin
                for (int k = 0; k < word_len; k++)
                    table_chars[table_used][k] = word_buf[k];
                table_len[table_used] = word_len;
                table_used++;
            end
            else
                saw_drop = 1'b1;
        end
        word_len = 0;
    endfunction

    function automatic void clear_sentence();
        table_used = 0;
        word_len   = 0;
        word_total = 0;
        saw_long   = 1'b0;
        saw_drop   = 1'b0;
    endfunction

    function automatic void absorb_byte(input in_item_t item);
        out_item_t totals;
        if (item.char_code == SEPARATOR)
            close_word();
        else if (word_len < MAX_LEN)
        begin
            word_buf[word_len] = item.char_code;
            word_len++;
        end
        else
            saw_long = 1'b1;
        if (item.last)
        begin
            close_word();
            totals.word_count     = 16'(word_total);
            totals.distinct_count = 6'(table_used);
            totals.word_truncated = saw_long;
            totals.table_full     = saw_drop;
            expected_totals.push_back(totals);
            clear_sentence();
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_checked++;
        if (expected_totals.size() == 0)
        begin
            report_mismatch("word_count of a result with no sentence behind it",
                            got.word_count, 0);
            return;
        end
        want = expected_totals.pop_front();
        if (got.word_count !== want.word_count)
            report_mismatch("word_count", got.word_count, want.word_count);
        if (got.distinct_count !== want.distinct_count)
            report_mismatch("distinct_count", got.distinct_count, want.distinct_count);
        if (got.word_truncated !== want.word_truncated)
            report_mismatch("word_truncated", got.word_truncated, want.word_truncated);
        if (got.table_full !== want.table_full)
            report_mismatch("table_full", got.table_full, want.table_full);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sentence();
            expected_totals.delete();
            results_waiting <= 0;
        end
        else
        begin
            if (char_valid && !char_stall)
                absorb_byte(char_data);
            if (result_valid && !result_stall)
                check_result(result_data);
            results_waiting <= expected_totals.size();
        end
    end

endmodule

// ===== tb/tb_distinct_word_counter_top.sv =====
// ----------------------------------------------------------------------------
// Distinct word counter testbench
// Sends directed sentences (empty, stray spaces, zero and all-ones bytes,
// long words, a full table) and then random sentences with bursty input
// and a stalling receiver. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_distinct_word_counter_top;
    import dwc_pkg::*;

    localparam int MAX_WORDS         = DEF_MAX_WORDS;
    localparam int MAX_LEN           = DEF_MAX_LEN;
    localparam int RANDOM_BYTES      = 1350;
    localparam int CYCLE_LIMIT       = 500_000;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    in_item_t  char_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_data;

    int         mismatches;
    int         results_checked;
    int         results_waiting;
    int         bytes_sent;
    int         sentences_sent;
    int         burst_left;
    logic [7:0] sentence [$];

    distinct_word_counter_top #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    distinct_word_checker #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_stall      (char_stall),
        .char_data       (char_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_data     (result_data),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .results_waiting (results_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycles, results_waiting);
        $display("Mismatches found");
        $finish;
    end

    // The receiver switches between free running, light and heavy stalling.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (mode == 0)
                result_stall <= 1'b0;
            else if (mode == 1)
                result_stall <= ($urandom_range(0, 2) == 0);
            else
                result_stall <= ($urandom_range(0, 9) < 8);
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] code, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        char_valid <= 1'b1;
        char_data  <= '{char_code: code, last: fin};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_sentence();
        foreach (sentence[i])
            send_byte(sentence[i], i == sentence.size() - 1);
        sentence.delete();
        sentences_sent++;
    endtask

    function automatic void append_text(input string text);
        for (int i = 0; i < text.len(); i++)
            sentence.push_back(text[i]);
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == SEPARATOR)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Mostly real sentences: short words over a tiny alphabet so repeats are
    // common, random byte words, and long words sharing a 15 byte prefix so
    // that truncated words collide. Wide sentences overflow the table.
    task automatic build_random_sentence();
        int    pick;
        int    n_words;
        int    kind;
        bit    wide;
        string letters;
        letters = "abA";
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 4)) sentence.push_back(SEPARATOR);
            return;
        end
        wide = (pick >= 90);
        if (pick < 70)
            n_words = $urandom_range(1, 8);
        else if (wide)
            n_words = $urandom_range(MAX_WORDS + 1, MAX_WORDS + 12);
        else
            n_words = $urandom_range(9, MAX_WORDS - 1);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) sentence.push_back(SEPARATOR);
        for (int w = 0; w < n_words; w++)
        begin
            if (w > 0)
                repeat (($urandom_range(0, 4) == 0) ? 2 : 1) sentence.push_back(SEPARATOR);
            kind = wide ? $urandom_range(50, 89) : $urandom_range(0, 99);
            if (kind < 50)
            begin
                repeat ($urandom_range(1, 3))
                    sentence.push_back(letters[$urandom_range(0, 2)]);
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(wide ? 2 : 1, 6)) sentence.push_back(word_byte());
            end
            else
            begin
                repeat (MAX_LEN - 1) sentence.push_back("L");
                sentence.push_back($urandom_range(0, 1) ? "x" : "y");
                repeat ($urandom_range(0, 3)) sentence.push_back(word_byte());
            end
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) sentence.push_back(SEPARATOR);
    endtask

    initial
    begin
        int first_random_byte;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A final space alone, then a single byte closed by the final flag.
        sentence.push_back(SEPARATOR);
        send_sentence();
        append_text("x");
        send_sentence();
        append_text("  ab  ab Ab ");
        send_sentence();

        // Zero and all-ones bytes are ordinary word characters.
        sentence = '{8'h00, 8'hFF, SEPARATOR, 8'h00, 8'hFF, 8'h00, SEPARATOR,
                     8'h80, 8'h7F, SEPARATOR, 8'h00, 8'hFF};
        send_sentence();

        // Words at and past the length limit compare by their first bytes,
        // and the final byte itself is one that gets dropped.
        append_text("abcdefghijklmnop abcdefghijklmnopq abcdefghijklmnopZZ ");
        append_text("abcdefghijklmnopqrs");
        send_sentence();

        // Exactly as many distinct words as the table holds, then two more than it holds.
        for (int i = 0; i < MAX_WORDS; i++)
            append_text($sformatf("w%0d ", i));
        append_text("w7");
        send_sentence();
        for (int i = 0; i <= MAX_WORDS; i++)
            append_text($sformatf("w%0d ", i));
        append_text("w5 w99");
        send_sentence();

        first_random_byte = bytes_sent;
        while (bytes_sent - first_random_byte < RANDOM_BYTES)
        begin
            build_random_sentence();
            send_sentence();
        end

        char_valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (MAX_WORDS + 8) @(posedge clk);

        $display("Ran %0d bytes in %0d sentences, with stray spaces, long words",
                 bytes_sent, sentences_sent);
        $display("and full tables; %0d results checked.", results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== distinct_word_counter_top.f =====
+incdir+design
design/dwc_pkg.sv
design/dwc_cell.sv
design/distinct_word_counter_top.sv
tb/distinct_word_checker.sv
tb/tb_distinct_word_counter_top.sv
